// File: hw/rtl/gtbq_pkg.sv
// ----------------------------------------------------------------------------
// Grid tile binning package
// Shared widths, register indexes and defaults for the grid tile binning block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtbq_pkg;

    localparam int unsigned ENT_W     = 16;
    localparam int unsigned POS_W     = 20;
    localparam int unsigned TILE_W    = 16;
    localparam int unsigned SIZE_W    = 16;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 20;

    // Quotient width: covers a rectangle end rounded up by one tile.
    localparam int unsigned QUO_W = POS_W + 2;

    localparam int unsigned LANES = 6;

    localparam int unsigned DEFAULT_COLUMNS = 64;

    localparam logic [SIZE_W-1:0] TILE_SIZE_RESET = SIZE_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_WIDTH  = 4'd0,
        REG_TILE_HEIGHT = 4'd1,
        REG_QUERY_MODE  = 4'd2,
        REG_QUERY_TILE  = 4'd3,
        REG_RECT_X      = 4'd4,
        REG_RECT_Y      = 4'd5,
        REG_RECT_W      = 4'd6,
        REG_RECT_H      = 4'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        LANE_X      = 3'd0,
        LANE_Y      = 3'd1,
        LANE_RX0    = 3'd2,
        LANE_RY0    = 3'd3,
        LANE_RX1    = 3'd4,
        LANE_RY1    = 3'd5
    } lane_t;

endpackage

`default_nettype wire

// File: hw/rtl/grid_tile_bin_and_query.sv
// ----------------------------------------------------------------------------
// Grid tile binning and query
// Bins entity positions into a uniform grid and flags tile or rectangle hits.
// ----------------------------------------------------------------------------
// One request enters and one result leaves per clock while the output is not stalled.
// Each request passes a numerator preparation register, a chain of stages in six
// parallel restoring divider lanes that produce one quotient bit per stage, and
// the output register for the tile index and match compare. The whole pipeline
// stalls when the result is not taken. Configuration must be written by the user
// through the plain write port while idle; the block does not enforce this.
`default_nettype none

module grid_tile_bin_and_query
    import gtbq_pkg::*;
#(
    parameter int unsigned COLUMNS = DEFAULT_COLUMNS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,

    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic [ENT_W-1:0]     s_entity_index,
    input  wire logic [POS_W-1:0]     s_x_pos,
    input  wire logic [POS_W-1:0]     s_y_pos,

    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      logic [ENT_W-1:0]     m_entity_echo,
    output      logic [TILE_W-1:0]    m_tile_index,
    output      logic                 m_hit
);

    localparam int unsigned NSTG = QUO_W + 1;

    logic [SIZE_W-1:0] tile_width_reg;
    logic [SIZE_W-1:0] tile_height_reg;
    logic              query_mode_reg;
    logic [TILE_W-1:0] query_tile_reg;
    logic [POS_W-1:0]  rect_x_reg;
    logic [POS_W-1:0]  rect_y_reg;
    logic [POS_W-1:0]  rect_w_reg;
    logic [POS_W-1:0]  rect_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg  <= TILE_SIZE_RESET;
            tile_height_reg <= TILE_SIZE_RESET;
            query_mode_reg  <= 1'b0;
            query_tile_reg  <= '0;
            rect_x_reg      <= '0;
            rect_y_reg      <= '0;
            rect_w_reg      <= '0;
            rect_h_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data[SIZE_W-1:0];
                REG_QUERY_MODE:  query_mode_reg  <= cfg_data[0];
                REG_QUERY_TILE:  query_tile_reg  <= cfg_data[TILE_W-1:0];
                REG_RECT_X:      rect_x_reg      <= cfg_data;
                REG_RECT_Y:      rect_y_reg      <= cfg_data;
                REG_RECT_W:      rect_w_reg      <= cfg_data;
                REG_RECT_H:      rect_h_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [SIZE_W-1:0] tw;
    logic [SIZE_W-1:0] th;
    logic [SIZE_W-1:0] lane_div [LANES];

    assign tw = (tile_width_reg == '0) ? SIZE_W'(1) : tile_width_reg;
    assign th = (tile_height_reg == '0) ? SIZE_W'(1) : tile_height_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_div[l] = (l % 2 == 0) ? tw : th;
        end
    end

    logic adv;
    logic out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    logic              vld_reg [NSTG];
    logic [ENT_W-1:0]  ent_reg [NSTG];
    logic [QUO_W-1:0]  nq_reg  [NSTG][LANES];
    logic [SIZE_W-1:0] rem_reg [NSTG][LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTG; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < NSTG; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ent_reg[0] <= s_entity_index;
            nq_reg[0][LANE_X]   <= QUO_W'(s_x_pos);
            nq_reg[0][LANE_Y]   <= QUO_W'(s_y_pos);
            nq_reg[0][LANE_RX0] <= QUO_W'(rect_x_reg);
            nq_reg[0][LANE_RY0] <= QUO_W'(rect_y_reg);
            nq_reg[0][LANE_RX1] <= QUO_W'(rect_x_reg) + QUO_W'(rect_w_reg)
                                   + QUO_W'(tw) - QUO_W'(1);
            nq_reg[0][LANE_RY1] <= QUO_W'(rect_y_reg) + QUO_W'(rect_h_reg)
                                   + QUO_W'(th) - QUO_W'(1);
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= '0;
            end
        end
    end

    for (genvar k = 1; k < NSTG; k++) begin : g_div
        logic [SIZE_W:0] trial [LANES];
        logic            ge    [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {rem_reg[k-1][l], nq_reg[k-1][l][QUO_W-1]};
                ge[l]    = trial[l] >= {1'b0, lane_div[l]};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ent_reg[k] <= ent_reg[k-1];
                for (int l = 0; l < LANES; l++) begin
                    nq_reg[k][l]  <= {nq_reg[k-1][l][QUO_W-2:0], ge[l]};
                    rem_reg[k][l] <= ge[l] ? SIZE_W'(trial[l] - {1'b0, lane_div[l]})
                                           : SIZE_W'(trial[l]);
                end
            end
        end
    end

    logic [QUO_W-1:0]  col;
    logic [QUO_W-1:0]  row;
    logic [TILE_W-1:0] tile;
    logic              hit;

    assign col  = nq_reg[NSTG-1][LANE_X];
    assign row  = nq_reg[NSTG-1][LANE_Y];
    assign tile = TILE_W'(row[TILE_W-1:0] * TILE_W'(COLUMNS)) + col[TILE_W-1:0];

    always_comb begin
        if (query_mode_reg) begin
            hit = (col >= nq_reg[NSTG-1][LANE_RX0]) && (col < nq_reg[NSTG-1][LANE_RX1])
               && (row >= nq_reg[NSTG-1][LANE_RY0]) && (row < nq_reg[NSTG-1][LANE_RY1]);
        end else begin
            hit = (tile == query_tile_reg);
        end
    end

    logic [ENT_W-1:0]  out_ent_reg;
    logic [TILE_W-1:0] out_tile_reg;
    logic              out_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_ent_reg  <= ent_reg[NSTG-1];
            out_tile_reg <= tile;
            out_hit_reg  <= hit;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_entity_echo = out_ent_reg;
    assign m_tile_index  = out_tile_reg;
    assign m_hit         = out_hit_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gtbq_checker.sv
// ----------------------------------------------------------------------------
// Grid tile binning checker
// Port-level checks on request flow and result hold for the binning block.
// ----------------------------------------------------------------------------
`default_nettype none

module gtbq_checker
    import gtbq_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [TILE_W-1:0] m_tile_index,
    input wire logic              m_hit
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_accept_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("Input ready does not follow output space.");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Result dropped before it was taken.");

    a_payload_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_tile_index) && $stable(m_hit))
        else $error("Result changed while stalled.");

endmodule

bind grid_tile_bin_and_query gtbq_checker u_gtbq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_tile_index (m_tile_index),
    .m_hit        (m_hit)
);

`default_nettype wire
